@@ hw/rtl/impq_pkg.sv @@
// Package for the indexed max priority queue: request/response structs and command codes.
// No dependencies.
package impq_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned IdW = 8;
  localparam int unsigned PrioW = 32;
  localparam int unsigned CountW = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_RAISE  = 3'd1,
    CMD_LOWER  = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [IdW-1:0]           id;
    logic signed [PrioW-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [IdW-1:0]           out_id;
    logic signed [PrioW-1:0]  out_priority;
    logic [CountW-1:0]        count;
  } rsp_t;

endpackage

@@ hw/rtl/impq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module impq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/indexed_max_priority_queue_core.sv @@
// Top level of the indexed max priority queue: sequencer, memories and one key comparator.
// Depends on impq_pkg and impq_ram.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------
//  req     | in        | req_valid, req_ready, req (command/id/priority_req)
//  rsp     | out       | rsp_valid, rsp_ready, rsp (ok/out_id/out_priority/count)
//
// Each request is handled by a sequencer that reads one word per memory per cycle.
// A query or a rejected request runs through S_DECODE, S_KEYRD and S_DONE before the next
// acceptance. Each upward sift level runs S_UPP, S_UPID, S_UPCMP and S_SWAP; each downward
// level S_DNL, S_DNLID, S_DNR, S_DNRK and S_SWAP, plus setup, placement and response.
// Reset clears the presence bits and the element count; no clearing pass is needed.
// A finished request waits until the response register is empty or being drained.
module indexed_max_priority_queue_core
  import impq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000_0000_0000_0001,
    S_DECODE = 15'b000_0000_0000_0010,
    S_KEYRD  = 15'b000_0000_0000_0100,
    S_START  = 15'b000_0000_0000_1000,
    S_FETCHK = 15'b000_0000_0001_0000,
    S_UPP    = 15'b000_0000_0010_0000,
    S_UPID   = 15'b000_0000_0100_0000,
    S_UPCMP  = 15'b000_0000_1000_0000,
    S_SWAP   = 15'b000_0001_0000_0000,
    S_DNL    = 15'b000_0010_0000_0000,
    S_DNLID  = 15'b000_0100_0000_0000,
    S_DNR    = 15'b000_1000_0000_0000,
    S_DNRK   = 15'b001_0000_0000_0000,
    S_PLACE  = 15'b010_0000_0000_0000,
    S_DONE   = 15'b100_0000_0000_0000
  } state_t;

  state_t state;

  // Memories: heap slot -> id, id -> key, id -> slot.
  logic          hs_we, ki_we, si_we;
  logic [AW-1:0] hs_wa, hs_ra, ki_wa, ki_ra, si_wa, si_ra;
  logic [AW-1:0] hs_wd, hs_rd, si_wd, si_rd;
  logic [PrioW-1:0] ki_wd, ki_rd;

  impq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
  impq_ram #(.WIDTH(PrioW), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(ki_we), .waddr(ki_wa), .wdata(ki_wd), .raddr(ki_ra), .rdata(ki_rd));
  impq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_slot (
    .clk(clk), .we(si_we), .waddr(si_wa), .wdata(si_wd), .raddr(si_ra), .rdata(si_rd));

  logic [CAPACITY-1:0] present;
  logic [CW-1:0]       count;

  req_t          cur;
  logic          id_ok;
  logic          ok_pre;
  logic          is_lower;
  logic [AW-1:0] cid;
  logic          down;        // sift direction
  logic [AW-1:0] pos;         // slot of the moving entry
  logic [AW-1:0] pos_id;      // id of the moving entry
  logic signed [PrioW-1:0] pos_key;
  logic [AW-1:0] parent;
  logic [AW-1:0] oth;         // parent or best child slot
  logic [AW-1:0] oth_id;
  logic signed [PrioW-1:0] oth_key;
  logic [AW-1:0] rch;         // right child slot
  logic [AW-1:0] r_id;
  logic          has_r;
  logic          l_gt;
  logic          ok_r;
  logic [IdW-1:0] oid_r;
  logic signed [PrioW-1:0] opr_r;

  // Child slot indices, computed wide so an overflow past the count is seen.
  logic [CW:0] lc_w, rc_w;
  assign lc_w = {{(CW-AW){1'b0}}, pos, 1'b1};
  assign rc_w = lc_w + (CW+1)'(1);
  assign parent = (pos - AW'(1)) >> 1;

  // The one shared comparator: is a greater than b.
  logic signed [PrioW-1:0] cmp_a, cmp_b;
  logic                    cmp_gt;
  assign cmp_gt = cmp_a > cmp_b;

  assign is_lower = (cur.command == CMD_LOWER);

  always_comb begin
    case (state)
      S_KEYRD: begin
        cmp_a = is_lower ? ki_rd : cur.priority_req;
        cmp_b = is_lower ? cur.priority_req : ki_rd;
      end
      S_UPCMP: begin
        cmp_a = pos_key;
        cmp_b = ki_rd;
      end
      S_DNRK: begin
        cmp_a = ki_rd;
        cmp_b = oth_key;
      end
      default: begin
        cmp_a = ki_rd;
        cmp_b = pos_key;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);
  assign id_ok = (32'(req.id) < CAPACITY);

  always_comb begin
    case (req.command)
      CMD_INSERT: ok_pre = id_ok && !present[AW'(req.id)] && (count < CW'(CAPACITY));
      CMD_RAISE, CMD_LOWER, CMD_QUERY: ok_pre = id_ok && present[AW'(req.id)];
      CMD_REMOVE: ok_pre = (count != '0);
      default: ok_pre = 1'b0;
    endcase
  end

  // The moving entry is written to its final slot only once, when the sift ends.
  always_comb begin
    hs_we = 1'b0; hs_wa = pos; hs_wd = pos_id; hs_ra = pos;
    ki_we = 1'b0; ki_wa = cid; ki_wd = cur.priority_req; ki_ra = cid;
    si_we = 1'b0; si_wa = pos_id; si_wd = pos; si_ra = cid;
    case (state)
      S_DECODE: begin
        // Remove reads the root id; insert stores the new key.
        hs_ra = '0;
        ki_we = (cur.command == CMD_INSERT) && ok_r;
      end
      S_KEYRD: begin
        if (cur.command == CMD_REMOVE) begin
          hs_ra = AW'(count - CW'(1));
          ki_ra = hs_rd;
        end
        ki_we = ok_r && (cur.command == CMD_RAISE || is_lower) && cmp_gt;
      end
      S_START: ki_ra = hs_rd;
      S_UPP: hs_ra = parent;
      S_UPID: ki_ra = hs_rd;
      S_DNL: hs_ra = lc_w[AW-1:0];
      S_DNLID: begin
        ki_ra = hs_rd;
        hs_ra = rch;
      end
      S_DNR: ki_ra = hs_rd;
      S_SWAP: begin
        hs_we = 1'b1; hs_wd = oth_id;
        si_we = 1'b1; si_wa = oth_id;
      end
      S_PLACE: begin
        hs_we = 1'b1;
        si_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      present <= '0;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            cid <= AW'(req.id);
            oid_r <= req.id;
            opr_r <= '0;
            ok_r <= ok_pre;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (cur.command == CMD_INSERT && ok_r) begin
            present[cid] <= 1'b1;
            count <= count + CW'(1);
            pos <= AW'(count);
            pos_id <= cid;
            pos_key <= cur.priority_req;
            down <= 1'b0;
          end
          state <= S_KEYRD;
        end
        S_KEYRD: begin
          // ki_rd = key of cid, si_rd = slot of cid, hs_rd = root id.
          case (cur.command)
            CMD_INSERT: state <= ok_r ? S_UPP : S_DONE;
            CMD_RAISE, CMD_LOWER: begin
              if (ok_r && cmp_gt) begin
                pos <= si_rd;
                pos_id <= cid;
                pos_key <= cur.priority_req;
                down <= is_lower;
                state <= is_lower ? S_DNL : S_UPP;
              end else begin
                ok_r <= 1'b0;
                state <= S_DONE;
              end
            end
            CMD_QUERY: begin
              if (ok_r) opr_r <= ki_rd;
              state <= S_DONE;
            end
            CMD_REMOVE: begin
              if (ok_r) begin
                oid_r <= IdW'(hs_rd);
                cid <= hs_rd;
                state <= S_START;
              end else begin
                state <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_START: begin
          // ki_rd holds the root key and hs_rd the last entry's id.
          opr_r <= ki_rd;
          present[cid] <= 1'b0;
          count <= count - CW'(1);
          pos <= '0;
          pos_id <= hs_rd;
          down <= 1'b1;
          state <= S_FETCHK;
        end
        S_FETCHK: begin
          pos_key <= ki_rd;
          state <= (count == '0) ? S_DONE : S_DNL;
        end
        S_UPP: begin
          if (pos == '0) begin
            state <= S_PLACE;
          end else begin
            oth <= parent;
            state <= S_UPID;
          end
        end
        S_UPID: begin
          oth_id <= hs_rd;
          state <= S_UPCMP;
        end
        S_UPCMP: state <= cmp_gt ? S_SWAP : S_PLACE;
        S_SWAP: begin
          pos <= oth;
          state <= down ? S_DNL : S_UPP;
        end
        S_DNL: begin
          if (lc_w >= {1'b0, count}) begin
            state <= S_PLACE;
          end else begin
            oth <= lc_w[AW-1:0];
            rch <= rc_w[AW-1:0];
            has_r <= (rc_w < {1'b0, count});
            state <= S_DNLID;
          end
        end
        S_DNLID: begin
          oth_id <= hs_rd;
          state <= S_DNR;
        end
        S_DNR: begin
          // The best key so far is the left child's if it beats the moving entry.
          l_gt <= cmp_gt;
          oth_key <= cmp_gt ? ki_rd : pos_key;
          r_id <= hs_rd;
          state <= S_DNRK;
        end
        S_DNRK: begin
          if (has_r && cmp_gt) begin
            oth <= rch;
            oth_id <= r_id;
            state <= S_SWAP;
          end else begin
            state <= l_gt ? S_SWAP : S_PLACE;
          end
        end
        S_PLACE: state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.ok <= ok_r;
            rsp.out_id <= oid_r;
            rsp.out_priority <= opr_r;
            rsp.count <= CountW'(count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
